// ===== hdl/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants of the feedback rate controller
// Request and result payloads, mode codes and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  // update modes
  typedef enum logic [1:0] {
    MODE_ADDITIVE = 2'd0,
    MODE_AIMD     = 2'd1,
    MODE_PROP     = 2'd2,
    MODE_PROP_RATE = 2'd3
  } frc_mode_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE            = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECREASE_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE    = 3'd5;

  localparam int unsigned CFG_DATA_W = 32;

  // register reset values
  localparam logic [31:0] STEP_SIZE_RST       = 32'h0001_0000;
  localparam logic [16:0] DECREASE_FACTOR_RST = 17'h0_8000;
  localparam logic [23:0] LEVEL_GAIN_RST      = 24'h01_0000;
  localparam logic [16:0] RATE_GAIN_RST       = 17'h0_0000;
  localparam logic [31:0] INITIAL_RATE_RST    = 32'h0001_0000;

  // signed width of the exact update before clamping
  localparam int unsigned SUM_W = 44;

  // feedback request
  typedef struct packed {
    logic [31:0] buffer_level;
    logic [31:0] target_level;
    logic [31:0] target_rate;
  } frc_req_t;

  // rate result
  typedef struct packed {
    logic [31:0] new_rate;
    logic        clamped;
  } frc_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/feedback_rate_controller.sv =====
// ----------------------------------------------------------------------------
// feedback_rate_controller: send rate update from client feedback
// Additive, AIMD and proportional rate control on unsigned Q16.16 values.
// ----------------------------------------------------------------------------
// One feedback request is taken per clock cycle while the receiver keeps taking
// results. A request lands in an input register; once the output register can
// take a result, the rate update is computed from the request and the stored
// send rate, and the result moves to the output register while the send rate
// register takes the new value. The sustained figure of one request per cycle
// is set by the loop through the send rate register alone, which feeds the next
// request's update. The output register lets the next request be accepted
// while a finished result still waits. Configuration writes take effect at
// once; writing the initial rate reloads the send rate (zero loads one LSB).
`default_nettype none

module feedback_rate_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [frc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // feedback requests
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire frc_pkg::frc_req_t                 in_req_i,
  // rate results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output frc_pkg::frc_rsp_t                      out_rsp_o
);

  import frc_pkg::*;

  // configuration registers
  frc_mode_e   mode_q;
  logic [31:0] step_size_q;
  logic [16:0] decrease_factor_q;
  logic [23:0] level_gain_q;
  logic [16:0] rate_gain_q;
  logic [31:0] initial_rate_q;
  logic [31:0] send_rate_q;
  logic [31:0] send_rate_d;

  // pipeline registers
  logic     in_valid_q;
  frc_req_t in_req_q;
  logic     out_valid_q;
  frc_rsp_t out_rsp_q;
  frc_rsp_t out_rsp_d;

  logic adv;
  logic xfer;

  // handshake control
  assign adv        = !out_valid_q || out_ready_i;
  assign xfer       = in_valid_q && adv;
  assign in_ready_o = !in_valid_q || adv;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q            <= MODE_ADDITIVE;
      step_size_q       <= STEP_SIZE_RST;
      decrease_factor_q <= DECREASE_FACTOR_RST;
      level_gain_q      <= LEVEL_GAIN_RST;
      rate_gain_q       <= RATE_GAIN_RST;
      initial_rate_q    <= INITIAL_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:            mode_q            <= frc_mode_e'(cfg_data_i[1:0]);
        REG_STEP_SIZE:       step_size_q       <= cfg_data_i[31:0];
        REG_DECREASE_FACTOR: decrease_factor_q <= cfg_data_i[16:0];
        REG_LEVEL_GAIN:      level_gain_q      <= cfg_data_i[23:0];
        REG_RATE_GAIN:       rate_gain_q       <= cfg_data_i[16:0];
        REG_INITIAL_RATE:    initial_rate_q    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // level error magnitude and sign
  logic        lvl_neg;
  logic [31:0] lvl_mag;
  logic [55:0] lvl_prod;
  logic [39:0] lvl_term_mag;

  // rate excess magnitude and sign
  logic        rate_neg;
  logic [31:0] rate_mag;
  logic [48:0] rate_prod;
  logic [32:0] rate_term_mag;

  // multiplicative decrease
  logic [48:0] dec_prod;
  logic [32:0] dec_rate;

  logic signed [SUM_W-1:0] cur_s;
  logic signed [SUM_W-1:0] step_s;
  logic signed [SUM_W-1:0] lvl_term;
  logic signed [SUM_W-1:0] rate_term;
  logic signed [SUM_W-1:0] next_full;
  logic                    lvl_lt;
  logic                    lvl_gt;

  assign lvl_lt = in_req_q.buffer_level < in_req_q.target_level;
  assign lvl_gt = in_req_q.buffer_level > in_req_q.target_level;

  // products, truncated on magnitude
  always_comb begin
    lvl_neg  = lvl_gt;
    lvl_mag  = lvl_neg ? (in_req_q.buffer_level - in_req_q.target_level)
                       : (in_req_q.target_level - in_req_q.buffer_level);
    lvl_prod = 56'(level_gain_q) * 56'(lvl_mag);
    lvl_term_mag = lvl_prod[55:16];

    rate_neg  = send_rate_q < in_req_q.target_rate;
    rate_mag  = rate_neg ? (in_req_q.target_rate - send_rate_q)
                         : (send_rate_q - in_req_q.target_rate);
    rate_prod = 49'(rate_gain_q) * 49'(rate_mag);
    rate_term_mag = rate_prod[48:16];

    dec_prod = 49'(send_rate_q) * 49'(decrease_factor_q);
    dec_rate = dec_prod[48:16];

    cur_s     = $signed(SUM_W'(send_rate_q));
    step_s    = $signed(SUM_W'(step_size_q));
    lvl_term  = lvl_neg ? -$signed(SUM_W'(lvl_term_mag)) : $signed(SUM_W'(lvl_term_mag));
    rate_term = rate_neg ? -$signed(SUM_W'(rate_term_mag))
                         : $signed(SUM_W'(rate_term_mag));
  end

  // exact update by mode
  always_comb begin
    next_full = cur_s;
    unique case (mode_q)
      MODE_ADDITIVE: begin
        if (lvl_lt) begin
          next_full = cur_s + step_s;
        end else if (lvl_gt) begin
          next_full = cur_s - step_s;
        end
      end
      MODE_AIMD: begin
        if (lvl_lt) begin
          next_full = cur_s + step_s;
        end else if (lvl_gt) begin
          next_full = $signed(SUM_W'(dec_rate));
        end
      end
      MODE_PROP: begin
        next_full = cur_s + lvl_term;
      end
      default: begin
        next_full = cur_s + lvl_term - rate_term;
      end
    endcase
  end

  // floor at one lsb, ceiling at full scale
  always_comb begin
    out_rsp_d.clamped = 1'b0;
    if (next_full < $signed(SUM_W'(1))) begin
      out_rsp_d.new_rate = 32'd1;
      out_rsp_d.clamped  = 1'b1;
    end else if (next_full > $signed(SUM_W'(32'hFFFF_FFFF))) begin
      out_rsp_d.new_rate = 32'hFFFF_FFFF;
      out_rsp_d.clamped  = 1'b1;
    end else begin
      out_rsp_d.new_rate = next_full[31:0];
    end
  end

  // send rate: reload on initial rate write, else follow the update
  always_comb begin
    send_rate_d = send_rate_q;
    if (cfg_we_i && (cfg_idx_i == REG_INITIAL_RATE)) begin
      send_rate_d = (cfg_data_i[31:0] == 32'd0) ? 32'd1 : cfg_data_i[31:0];
    end else if (xfer) begin
      send_rate_d = out_rsp_d.new_rate;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_rate_q <= INITIAL_RATE_RST;
    end else begin
      send_rate_q <= send_rate_d;
    end
  end

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_req_i;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// ===== dv/frc_rate_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frc_rate_checker: rate prediction and result comparison
// Tracks register writes and accepted feedback requests, keeps its own copy
// of the send rate, and compares every returned result in order.
// ----------------------------------------------------------------------------

module frc_rate_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [frc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [frc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_i,
  input  wire frc_pkg::frc_req_t              in_req_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_ready_i,
  input  wire frc_pkg::frc_rsp_t              out_rsp_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o,
  output int unsigned                         checked_o,
  output int unsigned                         clamp_count_o
);

  import frc_pkg::*;

  localparam longint RATE_CEIL = 64'h0000_0000_FFFF_FFFF;

  // shadow of the register file and the send rate
  frc_mode_e   mode_q;
  logic [31:0] step_q;
  logic [16:0] decrease_q;
  logic [23:0] level_gain_q;
  logic [16:0] rate_gain_q;
  logic [31:0] rate_q;

  frc_rsp_t    rates_due[$];
  frc_rsp_t    due;
  frc_rsp_t    fresh;

  // gain times signed difference, scaled down by 2^16, magnitude truncated
  function automatic longint gain_term(input logic [31:0] gain, input longint diff);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = ({32'd0, gain} * mag) >> 16;
    return (diff < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  // next send rate for one feedback request, limited to [1, max]
  function automatic frc_rsp_t update_rate(input frc_req_t req);
    longint      lvl;
    longint      tgt;
    longint      gam;
    longint      cur;
    longint      step;
    longint      nxt;
    logic [63:0] shrunk;
    frc_rsp_t    rsp;
    lvl  = longint'({32'd0, req.buffer_level});
    tgt  = longint'({32'd0, req.target_level});
    gam  = longint'({32'd0, req.target_rate});
    cur  = longint'({32'd0, rate_q});
    step = longint'({32'd0, step_q});
    nxt  = cur;
    case (mode_q)
      MODE_ADDITIVE: begin
        if (lvl < tgt) nxt = cur + step;
        else if (lvl > tgt) nxt = cur - step;
      end
      MODE_AIMD: begin
        if (lvl < tgt) begin
          nxt = cur + step;
        end else if (lvl > tgt) begin
          shrunk = ({32'd0, rate_q} * {47'd0, decrease_q}) >> 16;
          nxt = longint'(shrunk);
        end
      end
      MODE_PROP: nxt = cur + gain_term({8'd0, level_gain_q}, tgt - lvl);
      default: begin
        nxt = cur + gain_term({8'd0, level_gain_q}, tgt - lvl)
                  - gain_term({15'd0, rate_gain_q}, cur - gam);
      end
    endcase
    rsp.clamped = 1'b0;
    if (nxt < 1) begin
      nxt = 1;
      rsp.clamped = 1'b1;
    end else if (nxt > RATE_CEIL) begin
      nxt = RATE_CEIL;
      rsp.clamped = 1'b1;
    end
    rsp.new_rate = nxt[31:0];
    return rsp;
  endfunction

  // register writes, request prediction and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        = MODE_ADDITIVE;
      step_q        = STEP_SIZE_RST;
      decrease_q    = DECREASE_FACTOR_RST;
      level_gain_q  = LEVEL_GAIN_RST;
      rate_gain_q   = RATE_GAIN_RST;
      rate_q        = INITIAL_RATE_RST;
      rates_due.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      clamp_count_o = 0;
      pending_o     = 0;
    end else begin
      // results leaving the block
      if (out_valid_i && out_ready_i) begin
        if (rates_due.size() == 0) begin
          $display("%0t: result rate %h clamped %0b with no request outstanding",
                   $time, out_rsp_i.new_rate, out_rsp_i.clamped);
          fail_count_o++;
        end else begin
          due = rates_due.pop_front();
          checked_o++;
          if (due.clamped) clamp_count_o++;
          if (out_rsp_i.new_rate !== due.new_rate) begin
            $display("%0t: new_rate expected %h, got %h",
                     $time, due.new_rate, out_rsp_i.new_rate);
            fail_count_o++;
          end
          if (out_rsp_i.clamped !== due.clamped) begin
            $display("%0t: clamped expected %0b, got %0b",
                     $time, due.clamped, out_rsp_i.clamped);
            fail_count_o++;
          end
        end
      end

      // register writes, out-of-range indexes ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:            mode_q       = frc_mode_e'(cfg_data_i[1:0]);
          REG_STEP_SIZE:       step_q       = cfg_data_i;
          REG_DECREASE_FACTOR: decrease_q   = cfg_data_i[16:0];
          REG_LEVEL_GAIN:      level_gain_q = cfg_data_i[23:0];
          REG_RATE_GAIN:       rate_gain_q  = cfg_data_i[16:0];
          REG_INITIAL_RATE:    rate_q       = (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
          default: ;
        endcase
      end

      // feedback request accepted
      if (in_valid_i && in_ready_i) begin
        fresh  = update_rate(in_req_i);
        rate_q = fresh.new_rate;
        rates_due.push_back(fresh);
      end

      pending_o = rates_due.size();
    end
  end

endmodule

// ===== dv/tb_feedback_rate_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_feedback_rate_controller: testbench of the feedback rate controller
// Directed requests on the limits of each mode, then phases of random
// feedback under changing register settings, with random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_feedback_rate_controller;

  import frc_pkg::*;

  localparam int unsigned RUN_LIMIT = 200000;
  localparam int unsigned IDLE_PCT  = 17;
  localparam int unsigned N_PHASES  = 20;
  localparam int unsigned PHASE_LEN = 100;

  // indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  frc_req_t              in_req_i    = '0;
  logic                  out_ready_i = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  frc_rsp_t              out_rsp_o;

  logic                  calm = 1'b0;
  int unsigned           cycles = 0;
  int unsigned           sent = 0;
  int unsigned           settings = 0;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           checked;
  int unsigned           clamps;

  feedback_rate_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  frc_rate_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_req_i      (in_req_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_rsp_i     (out_rsp_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .clamp_count_o (clamps)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // result back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // cycle limit
  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // register write, then a spare wait with the write enable low
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // hold off requests until every result is back and the pipeline is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one feedback request, with random gaps in front of it
  task automatic send_feedback(input logic [31:0] lvl, input logic [31:0] tgt,
                               input logic [31:0] gam);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i             <= 1'b1;
    in_req_i.buffer_level  <= lvl;
    in_req_i.target_level  <= tgt;
    in_req_i.target_rate   <= gam;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  // field value biased towards the ends of the range
  function automatic logic [31:0] any_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(32'h0003_FFFF);
      default: return $urandom();
    endcase
  endfunction

  // register value around zero, unity and the top of the field
  function automatic logic [31:0] reg_value(input logic [31:0] unity,
                                            input logic [31:0] top);
    case ($urandom_range(5))
      0:       return '0;
      1:       return unity;
      2:       return top;
      3:       return $urandom_range(unity);
      default: return $urandom();
    endcase
  endfunction

  // new random register setting
  task automatic retune();
    write_reg(REG_MODE, $urandom());
    if ($urandom_range(1)) write_reg(REG_STEP_SIZE, reg_value(32'h0001_0000, '1));
    if ($urandom_range(1)) write_reg(REG_DECREASE_FACTOR, reg_value(32'h0001_0000, 32'h1_FFFF));
    if ($urandom_range(1)) write_reg(REG_LEVEL_GAIN, reg_value(32'h0001_0000, 32'hFF_FFFF));
    if ($urandom_range(1)) write_reg(REG_RATE_GAIN, reg_value(32'h0001_0000, 32'h1_FFFF));
    if ($urandom_range(2) == 0) write_reg(REG_INITIAL_RATE, any_value());
    if ($urandom_range(4) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
    end
    settings++;
  endtask

  // stimulus
  initial begin
    logic [31:0] lvl;
    logic [31:0] tgt;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // additive mode from reset: up, down, floor, equal levels
    send_feedback(32'h0, 32'hFFFF_FFFF, 32'h0);
    send_feedback(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_feedback(32'h1, 32'h0, 32'h0);
    send_feedback(32'h5, 32'h5, 32'h0);
    settle();
    // full step runs into the ceiling
    write_reg(REG_STEP_SIZE, 32'hFFFF_FFFF);
    send_feedback(32'h0, 32'h1, 32'h0);
    send_feedback(32'h2, 32'h2, 32'h0);
    settle();
    // aimd with a factor above one, then zero, then exactly one
    write_reg(REG_MODE, 32'(MODE_AIMD));
    write_reg(REG_DECREASE_FACTOR, 32'h1_FFFF);
    send_feedback(32'h9, 32'h3, 32'h0);
    send_feedback(32'h3, 32'h3, 32'h0);
    settle();
    write_reg(REG_DECREASE_FACTOR, 32'h0);
    send_feedback(32'h9, 32'h3, 32'h0);
    send_feedback(32'h3, 32'h9, 32'h0);
    settle();
    write_reg(REG_DECREASE_FACTOR, 32'h1_0000);
    send_feedback(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0);
    settle();
    // proportional mode from a zero initial rate, full gain both ways
    write_reg(REG_INITIAL_RATE, 32'h0);
    write_reg(REG_MODE, 32'(MODE_PROP));
    write_reg(REG_LEVEL_GAIN, 32'h00FF_FFFF);
    send_feedback(32'h0, 32'hFFFF_FFFF, 32'h0);
    send_feedback(32'hFFFF_FFFF, 32'h0, 32'h0);
    send_feedback(32'h7, 32'h7, 32'h0);
    settle();
    // rate term with a gain above one, spare indexes ignored
    write_reg(REG_INITIAL_RATE, 32'h0012_3456);
    write_reg(REG_MODE, 32'(MODE_PROP_RATE));
    write_reg(REG_RATE_GAIN, 32'h1_FFFF);
    write_reg(REG_LEVEL_GAIN, 32'h0000_8000);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    send_feedback(32'd100, 32'd200, 32'h0);
    send_feedback(32'h0, 32'h0, 32'hFFFF_FFFF);
    send_feedback(32'h0, 32'h0, 32'hFFFF_FFFF);
    send_feedback(32'h8000_0000, 32'h7FFF_0000, 32'h0001_0000);
    settle();
    settings = 6;

    // random phases, a few of them without gaps or stalls
    for (int p = 0; p < N_PHASES; p++) begin
      retune();
      calm = (p >= 6 && p < 9);
      for (int i = 0; i < PHASE_LEN; i++) begin
        lvl = any_value();
        case ($urandom_range(3))
          0:       tgt = lvl;
          1:       tgt = lvl + $urandom_range(32'h0002_0000) - 32'h0001_0000;
          default: tgt = any_value();
        endcase
        send_feedback(lvl, tgt, any_value());
      end
      settle();
    end
    calm = 1'b0;

    settle();
    repeat (8) @(negedge clk_i);
    $display("ran %0d feedback requests over %0d register settings in all four modes",
             sent, settings);
    $display("%0d results compared, %0d held at the floor or the ceiling", checked, clamps);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== feedback_rate_controller.f =====
hdl/frc_pkg.sv
hdl/feedback_rate_controller.sv
dv/frc_rate_checker.sv
dv/tb_feedback_rate_controller.sv
